### rtl/iph_pkg.sv
// Package for the incremental PID block with smoothed error history.
// Holds field widths, reset values, register codes and the stage structs.
// No dependencies.
package iph_pkg;

   // Field widths
   localparam int IN_W   = 16;          // measured / target
   localparam int GAIN_W = 16;          // Q8.8 gains
   localparam int WGT_W  = 9;           // history weight, out of 256
   localparam int OUT_W  = 24;          // delta_drive
   localparam int FRAC_W = 8;           // history fraction bits

   // Internal widths
   localparam int DIFF_W = IN_W + 1;                // target - measured
   localparam int ERR_W  = DIFF_W + FRAC_W;         // error in Q.8
   localparam int HIST_W = 26;                      // smoothed history
   localparam int HSUM_W = HIST_W + WGT_W;          // weighted history sum
   localparam int P_W    = HIST_W + 1;              // e - last
   localparam int D_W    = HIST_W + 2;              // e - 2*last + prev
   localparam int PP_W   = P_W + GAIN_W + 1;
   localparam int PI_W   = ERR_W + GAIN_W + 1;
   localparam int PD_W   = D_W + GAIN_W + 1;
   localparam int SUM_W  = PD_W + 2;
   localparam int PROD_FRAC_W = 2 * FRAC_W;         // Q.8 term times Q8.8 gain
   localparam int Q_W    = SUM_W - PROD_FRAC_W;

   localparam int OUT_MAX = 8388607;
   localparam int OUT_MIN = -8388608;
   localparam logic [WGT_W-1:0] WGT_ONE = 9'd256;

   // Reset values of the control registers
   localparam logic [GAIN_W-1:0] KP_RESET  = 16'd4608;
   localparam logic [GAIN_W-1:0] KI_RESET  = 16'd666;
   localparam logic [GAIN_W-1:0] KD_RESET  = 16'd0;
   localparam logic [WGT_W-1:0]  WGT_RESET = 9'd230;

   // Control register indexes
   typedef enum logic [1:0] {
      CSR_KP     = 2'd0,
      CSR_KI     = 2'd1,
      CSR_KD     = 2'd2,
      CSR_WEIGHT = 2'd3
   } csr_index_type;

   // Error terms handed from the history stage to the gain stage
   typedef struct packed {
      logic signed [ERR_W-1:0] e;
      logic signed [P_W-1:0]   p;
      logic signed [D_W-1:0]   d;
   } terms_type;

   // Gain products handed to the output stage
   typedef struct packed {
      logic signed [PP_W-1:0] pp;
      logic signed [PI_W-1:0] pi;
      logic signed [PD_W-1:0] pd;
   } prod_type;

endpackage

### rtl/iph_hist.sv
// Error forming and smoothed error history for the incremental PID block.
// Holds the last/prev history registers and produces the P, I and D terms.
// Depends on iph_pkg.
module iph_hist import iph_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     update,
   input  logic signed [IN_W-1:0]   measured,
   input  logic signed [IN_W-1:0]   target,
   input  logic [WGT_W-1:0]         history_weight,
   output terms_type                terms
);

   logic signed [DIFF_W-1:0] diff;
   logic signed [ERR_W-1:0]  err;
   logic signed [HIST_W-1:0] last_ff, last_in;
   logic signed [HIST_W-1:0] prev_ff, prev_in;
   logic [WGT_W-1:0]         w_new;
   logic [WGT_W-1:0]         w_old;
   logic signed [HSUM_W-1:0] last_sum;
   logic signed [HSUM_W-1:0] prev_sum;

   // Error in Q.8
   assign diff = DIFF_W'(target) - DIFF_W'(measured);
   assign err  = $signed({diff, {FRAC_W{1'b0}}});

   // Weights above one count as one
   assign w_new = history_weight[WGT_W-1] ? WGT_ONE : history_weight;
   assign w_old = WGT_ONE - w_new;

   // Weighted mixes, floor-scaled by 1/256
   assign last_sum = HSUM_W'($signed({1'b0, w_new})) * HSUM_W'(err)
                   + HSUM_W'($signed({1'b0, w_old})) * HSUM_W'(last_ff);
   assign prev_sum = HSUM_W'($signed({1'b0, w_new})) * HSUM_W'(last_ff)
                   + HSUM_W'($signed({1'b0, w_old})) * HSUM_W'(prev_ff);
   assign last_in  = last_sum[HIST_W+FRAC_W-1:FRAC_W];
   assign prev_in  = prev_sum[HIST_W+FRAC_W-1:FRAC_W];

   // PID terms from the history before this update
   always_comb begin
      terms.e = err;
      terms.p = P_W'(err) - P_W'(last_ff);
      terms.d = D_W'(err) - (D_W'(last_ff) <<< 1) + D_W'(prev_ff);
   end

   // History registers
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
         prev_ff <= '0;
      end else if (update) begin
         last_ff <= last_in;
         prev_ff <= prev_in;
      end
   end

endmodule

### rtl/iph_gain.sv
// Gain multiply stage of the incremental PID block.
// Multiplies the P, I and D terms by their Q8.8 gains into a register stage.
// Depends on iph_pkg.
module iph_gain import iph_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  terms_type         terms,
   input  logic [GAIN_W-1:0] kp,
   input  logic [GAIN_W-1:0] ki,
   input  logic [GAIN_W-1:0] kd,
   output logic              out_valid,
   output prod_type          prods
);

   logic     valid_ff;
   prod_type prods_ff, prods_in;

   // Unsigned gains times signed terms
   always_comb begin
      prods_in.pp = PP_W'($signed({1'b0, kp})) * PP_W'(terms.p);
      prods_in.pi = PI_W'($signed({1'b0, ki})) * PI_W'(terms.e);
      prods_in.pd = PD_W'($signed({1'b0, kd})) * PD_W'(terms.d);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en && in_valid) begin
         prods_ff <= prods_in;
      end
   end

   assign out_valid = valid_ff;
   assign prods     = prods_ff;

endmodule

### rtl/iph_sat.sv
// Output stage logic of the incremental PID block.
// Sums the gain products, truncates toward zero and saturates to 24 bits.
// Depends on iph_pkg.
module iph_sat import iph_pkg::*; (
   input  prod_type                prods,
   output logic signed [OUT_W-1:0] delta_drive,
   output logic                    clipped
);

   localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(OUT_MAX);
   localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(OUT_MIN);

   logic signed [SUM_W-1:0] sum;
   logic                    round_up;
   logic signed [Q_W-1:0]   quot;

   assign sum = SUM_W'(prods.pp) + SUM_W'(prods.pi) + SUM_W'(prods.pd);

   // Floor shift, then bump negative values with a fraction toward zero
   assign round_up = sum[SUM_W-1] && (|sum[PROD_FRAC_W-1:0]);
   assign quot     = $signed(sum[SUM_W-1:PROD_FRAC_W])
                   + $signed({{(Q_W-1){1'b0}}, round_up});

   always_comb begin
      if (quot > Q_MAX) begin
         delta_drive = OUT_W'(Q_MAX);
         clipped     = 1'b1;
      end else if (quot < Q_MIN) begin
         delta_drive = OUT_W'(Q_MIN);
         clipped     = 1'b1;
      end else begin
         delta_drive = quot[OUT_W-1:0];
         clipped     = 1'b0;
      end
   end

endmodule

### rtl/incremental_pid_smoothed_history.sv
// Incremental PID controller with smoothed error history, top level.
// Path from an accepted req transaction to rsp_tvalid: input register, term register,
// product register, then result register.
// Throughput: one item per cycle; the whole pipe stalls only while a result waits.
// Reset: synchronous, clears valids and history, loads the gain and weight defaults.
module incremental_pid_smoothed_history import iph_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: [15:0] measured, [31:16] target
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // rsp_tdata: [23:0] delta_drive
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   // rsp_tuser: [0] clipped
   output logic        rsp_tuser,
   // control register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic              en;
   logic [GAIN_W-1:0] kp_ff, ki_ff, kd_ff;
   logic [WGT_W-1:0]  wgt_ff;

   logic                   a_valid_ff;
   logic signed [IN_W-1:0] meas_ff, tgt_ff;
   terms_type              terms_in, terms_ff;
   logic                   b_valid_ff;
   logic                   c_valid;
   prod_type               prods;
   logic signed [OUT_W-1:0] delta_in;
   logic                   clip_in;
   logic                   rsp_valid_ff;
   logic signed [OUT_W-1:0] delta_ff;
   logic                   clip_ff;

   // Pipe advances whenever the result register is free or being drained
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff  <= KP_RESET;
         ki_ff  <= KI_RESET;
         kd_ff  <= KD_RESET;
         wgt_ff <= WGT_RESET;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_KP:     kp_ff  <= csr_data;
            CSR_KI:     ki_ff  <= csr_data;
            CSR_KD:     kd_ff  <= csr_data;
            CSR_WEIGHT: wgt_ff <= csr_data[WGT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en && req_tvalid) begin
         meas_ff <= $signed(req_tdata[IN_W-1:0]);
         tgt_ff  <= $signed(req_tdata[2*IN_W-1:IN_W]);
      end
   end

   // Error and history
   iph_hist u_hist (
      .clock          (clock),
      .reset          (reset),
      .update         (a_valid_ff && en),
      .measured       (meas_ff),
      .target         (tgt_ff),
      .history_weight (wgt_ff),
      .terms          (terms_in)
   );

   // Term register
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en && a_valid_ff) begin
         terms_ff <= terms_in;
      end
   end

   // Gain products
   iph_gain u_gain (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (b_valid_ff),
      .terms     (terms_ff),
      .kp        (kp_ff),
      .ki        (ki_ff),
      .kd        (kd_ff),
      .out_valid (c_valid),
      .prods     (prods)
   );

   // Sum, truncate, saturate
   iph_sat u_sat (
      .prods       (prods),
      .delta_drive (delta_in),
      .clipped     (clip_in)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= c_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en && c_valid) begin
         delta_ff <= delta_in;
         clip_ff  <= clip_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = delta_ff;
   assign rsp_tuser  = clip_ff;

   // A clipped result sits exactly on one of the limits
   a_clip_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && clip_ff) |-> (delta_ff == OUT_W'(OUT_MAX) || delta_ff == OUT_W'(OUT_MIN)))
      else $error("clipped result not at a saturation limit");

   // An empty result register never blocks the input
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_tready)
      else $error("input stalled with empty result register");

   // An item in the input register moves on to the term register when the pipe advances
   a_term_advance: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && en) |=> b_valid_ff)
      else $error("item lost between input and term registers");

endmodule

### bench/testbench.sv
// Self-checking bench for the incremental PID block with smoothed error history.
// Drives samples and gain and weight writes, predicts every result and checks each one.
// Depends on iph_pkg and incremental_pid_smoothed_history.
module testbench import iph_pkg::*; ();

   localparam int PHASES       = 6;
   localparam int PHASE_ITEMS  = 75;
   localparam int HOLD_CYCLES  = 80;    // long receiver hold-off
   localparam int QUIET_LIMIT  = 2000;  // cycles with no transaction at all
   localparam int DRAIN_CYCLES = 12;

   // One result: delta_drive plus the saturation flag
   typedef struct packed {
      logic signed [OUT_W-1:0] drive;
      logic                    clipped;
   } drive_result_type;

   // Directed stimulus: optional register write, then one sample
   typedef struct {
      bit                     cfg_en;
      csr_index_type          cfg_idx;
      logic [15:0]            cfg_val;
      logic signed [IN_W-1:0] meas;
      logic signed [IN_W-1:0] targ;
      bit                     known;
      drive_result_type       want;
   } plan_row_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = '0;
   logic [15:0] csr_data   = '0;

   incremental_pid_smoothed_history dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Predictor copy of the gains, weight and error history
   longint      gain_p, gain_i, gain_d;
   logic [8:0]  weight_raw;
   longint      hist_last, hist_prev;

   drive_result_type drive_expected[$];
   drive_result_type head;
   plan_row_type     plan[$];

   int  errors = 0;
   int  samples_sent = 0;
   int  reg_writes = 0;
   int  results_checked = 0;
   int  clipped_seen = 0;
   bit  no_idle = 1'b0;
   int  hold_offs_asked = 0;
   int  hold_offs_done = 0;
   int  setpoint_now = 0;
   int  plant_now = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Register write as seen by the predictor; weight keeps its low 9 bits
   function automatic void apply_reg(input csr_index_type idx, input logic [15:0] val);
      case (idx)
         CSR_KP:     gain_p = longint'(val);
         CSR_KI:     gain_i = longint'(val);
         CSR_KD:     gain_d = longint'(val);
         CSR_WEIGHT: weight_raw = val[8:0];
         default:    ;
      endcase
   endfunction

   // Incremental PID step: Q.16 sum, truncate toward zero, saturate, then smooth history
   function automatic drive_result_type predict_drive(input logic signed [IN_W-1:0] m,
                                                      input logic signed [IN_W-1:0] t);
      longint           err, w, p_part, d_part, acc, q;
      drive_result_type r;
      err    = (longint'(t) - longint'(m)) * 256;
      w      = (weight_raw > 9'd256) ? 256 : longint'(weight_raw);
      p_part = err - hist_last;
      d_part = err - 2 * hist_last + hist_prev;
      acc    = gain_p * p_part + gain_i * err + gain_d * d_part;
      q      = acc / 65536;
      r.clipped = 1'b0;
      if (q > OUT_MAX) begin
         q = OUT_MAX;
         r.clipped = 1'b1;
      end else if (q < OUT_MIN) begin
         q = OUT_MIN;
         r.clipped = 1'b1;
      end
      r.drive = q[OUT_W-1:0];
      // both updates use the old last value; >>> 8 is a floor divide
      hist_prev = (w * hist_last + (256 - w) * hist_prev) >>> 8;
      hist_last = (w * err + (256 - w) * hist_last) >>> 8;
      return r;
   endfunction

   function automatic void add_row(input bit cfg_en, input csr_index_type idx, input int val,
                                   input int m, input int t, input bit known,
                                   input int want_drive, input bit want_clip);
      plan_row_type r;
      r.cfg_en        = cfg_en;
      r.cfg_idx       = idx;
      r.cfg_val       = val[15:0];
      r.meas          = m[15:0];
      r.targ          = t[15:0];
      r.known         = known;
      r.want.drive    = want_drive[OUT_W-1:0];
      r.want.clipped  = want_clip;
      plan.push_back(r);
   endfunction

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(0, 5))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'($urandom_range(0, 1023));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [15:0] pick_weight();
      case ($urandom_range(0, 5))
         0:       return 16'd0;
         1:       return 16'd256;
         2:       return 16'($urandom_range(257, 511));
         3:       return 16'($urandom_range(0, 65535));
         default: return 16'($urandom_range(0, 256));
      endcase
   endfunction

   function automatic int clamp16(input int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // Write one register once every pending result is back
   task automatic write_reg(input csr_index_type idx, input logic [15:0] val);
      req_tvalid <= 1'b0;
      while (drive_expected.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      apply_reg(idx, val);
      reg_writes++;
   endtask

   // Offer one sample after a random gap; queue its expected result on acceptance
   task automatic push_sample(input logic signed [IN_W-1:0] m, input logic signed [IN_W-1:0] t,
                              input bit typed, input drive_result_type typed_res);
      int               gap;
      drive_result_type predicted;
      csr_valid <= 1'b0;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {t, m};
      do @(posedge clock); while (req_tready !== 1'b1);
      predicted = predict_drive(m, t);
      drive_expected.push_back(typed ? typed_res : predicted);
      samples_sent++;
   endtask

   // Random sample: noise, extremes, small errors, or a plant tracking a setpoint
   task automatic random_sample();
      int m, t;
      int corners[5];
      corners = '{-32768, -1, 0, 1, 32767};
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            m = int'($urandom_range(0, 65535)) - 32768;
            t = int'($urandom_range(0, 65535)) - 32768;
         end
         3: begin
            m = corners[$urandom_range(0, 4)];
            t = corners[$urandom_range(0, 4)];
         end
         4, 5: begin
            t = int'($urandom_range(0, 65535)) - 32768;
            m = clamp16(t + int'($urandom_range(0, 40)) - 20);
         end
         default: begin
            if ($urandom_range(0, 15) == 0)
               setpoint_now = int'($urandom_range(0, 65535)) - 32768;
            plant_now = clamp16(plant_now + (setpoint_now - plant_now) / 4
                                + int'($urandom_range(0, 8)) - 4);
            m = plant_now;
            t = setpoint_now;
         end
      endcase
      push_sample(m[15:0], t[15:0], 1'b0, '0);
   endtask

   // Result side: random stalls, occasional long hold-off
   initial begin : receiver
      int stall;
      forever begin
         if (hold_offs_done < hold_offs_asked) begin
            hold_offs_done++;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         stall = no_idle ? 0 : $urandom_range(0, 6);
         repeat (stall) begin
            rsp_tready <= 1'b0;
            @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
      end
   end

   // Compare each result transaction with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (drive_expected.size() == 0) begin
            $display("%0t: unexpected result delta_drive=%0d clipped=%0b",
                     $time, $signed(rsp_tdata), rsp_tuser);
            errors++;
         end else begin
            head = drive_expected.pop_front();
            results_checked++;
            if (rsp_tuser === 1'b1) clipped_seen++;
            if (rsp_tdata !== head.drive) begin
               $display("%0t: delta_drive expected %0d got %0d",
                        $time, head.drive, $signed(rsp_tdata));
               errors++;
            end
            if (rsp_tuser !== head.clipped) begin
               $display("%0t: clipped expected %0b got %0b", $time, head.clipped, rsp_tuser);
               errors++;
            end
         end
      end
   end

   // Watchdog: stop when nothing moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: timeout, %0d results still pending", $time, drive_expected.size());
      $display("FAILED: results differ");
      $finish;
   end

   initial begin : stimulus
      gain_p     = longint'(KP_RESET);
      gain_i     = longint'(KI_RESET);
      gain_d     = longint'(KD_RESET);
      weight_raw = WGT_RESET;
      hist_last  = 0;
      hist_prev  = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed rows; known results only where they follow at a glance
      add_row(0, CSR_KP, 0, 0, 0, 1, 0, 0);                       // defaults, zero error
      add_row(1, CSR_KP, 16'hFFFF, -32768, 32767, 1, OUT_MAX, 1); // top saturation
      add_row(0, CSR_KP, 0, 32767, -32768, 1, OUT_MIN, 1);        // bottom saturation
      add_row(1, CSR_KP, 0, 100, 100, 0, 0, 0);
      add_row(1, CSR_KI, 0, -5, 7, 0, 0, 0);
      add_row(1, CSR_KD, 0, -32768, 32767, 1, 0, 0);              // all gains zero
      add_row(1, CSR_KD, 16'hFFFF, 32767, -32768, 0, 0, 0);
      add_row(1, CSR_WEIGHT, 16'h01FF, 1, 0, 0, 0, 0);            // weight over 256
      add_row(1, CSR_WEIGHT, 0, -1, 5, 0, 0, 0);                  // frozen history
      add_row(1, CSR_WEIGHT, 256, 12345, -2345, 0, 0, 0);
      add_row(1, CSR_KP, 4608, 0, 1, 0, 0, 0);
      add_row(1, CSR_KI, 16'hFFFF, -32768, -32768, 0, 0, 0);
      add_row(1, CSR_WEIGHT, 16'hFFFF, 32767, 32767, 0, 0, 0);    // upper data bits dropped
      add_row(1, CSR_WEIGHT, 1, -100, -32768, 0, 0, 0);
      add_row(1, CSR_KD, 1, -32768, -32768, 0, 0, 0);
      add_row(1, CSR_KP, 1, 0, -1, 0, 0, 0);                      // tiny negative sum
      add_row(1, CSR_KI, 0, 3, 0, 0, 0, 0);
      add_row(1, CSR_WEIGHT, 230, 32767, 0, 0, 0, 0);
      add_row(0, CSR_KP, 0, -32768, 32767, 0, 0, 0);
      add_row(0, CSR_KP, 0, 0, 0, 0, 0, 0);

      foreach (plan[i]) begin
         if (plan[i].cfg_en) write_reg(plan[i].cfg_idx, plan[i].cfg_val);
         push_sample(plan[i].meas, plan[i].targ, plan[i].known, plan[i].want);
      end

      // Random phases, each with its own gains and weight
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin
               write_reg(CSR_KP, 16'hFFFF);
               write_reg(CSR_KI, 16'hFFFF);
               write_reg(CSR_KD, 16'hFFFF);
               write_reg(CSR_WEIGHT, 16'd256);
            end
            1: begin
               write_reg(CSR_KP, 16'h0000);
               write_reg(CSR_KI, 16'h0000);
               write_reg(CSR_KD, 16'hFFFF);
               write_reg(CSR_WEIGHT, 16'd0);
            end
            default: begin
               write_reg(CSR_KP, pick_gain());
               write_reg(CSR_KI, pick_gain());
               write_reg(CSR_KD, pick_gain());
               write_reg(CSR_WEIGHT, pick_weight());
            end
         endcase
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            no_idle = (k < 12);
            // stall the result side long enough to back up the input
            if (k == 0 && (ph == 2 || ph == 4)) hold_offs_asked++;
            random_sample();
         end
      end

      req_tvalid <= 1'b0;
      no_idle = 1'b0;
      while (drive_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run: %0d samples over %0d register writes, %0d results checked",
               samples_sent, reg_writes, results_checked);
      $display("     %0d saturated results, %0d mismatches", clipped_seen, errors);
      if (errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
